// ===== rtl/core/iba_pkg.sv =====
// Shared constants, register codes and payload types of the IMU block averager.
package iba_pkg;

   localparam int NUM_CH              = 7;
   localparam int DATA_W              = 32;
   localparam int STATUS_W            = 16;
   localparam int QUAT_N              = 4;
   localparam int BLOCK_SIZE_W        = 11;
   localparam int CSR_INDEX_W         = 2;
   localparam int CSR_DATA_W          = 11;
   localparam int DEFAULT_MAX_BLOCK   = 1024;
   localparam int DEFAULT_QUEUE_DEPTH = 2;

   localparam logic [DATA_W-1:0] QUAT_ONE = 32'h4000_0000;

   localparam logic [CSR_INDEX_W-1:0] CSR_BLOCK_SIZE = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_ORIENT_EN  = 2'd1;

   localparam logic [BLOCK_SIZE_W-1:0] BLOCK_SIZE_RESET = 11'd1;

   typedef struct packed {
      logic [BLOCK_SIZE_W-1:0] block_size;
      logic                    orientation_enable;
   } cfg_type;

   typedef struct packed {
      logic signed [DATA_W-1:0]   rate_x;
      logic signed [DATA_W-1:0]   rate_y;
      logic signed [DATA_W-1:0]   rate_z;
      logic signed [DATA_W-1:0]   accel_x;
      logic signed [DATA_W-1:0]   accel_y;
      logic signed [DATA_W-1:0]   accel_z;
      logic signed [DATA_W-1:0]   temperature;
      logic        [STATUS_W-1:0] status_word;
      logic signed [DATA_W-1:0]   quat_w;
      logic signed [DATA_W-1:0]   quat_x;
      logic signed [DATA_W-1:0]   quat_y;
      logic signed [DATA_W-1:0]   quat_z;
   } req_payload_type;

   typedef struct packed {
      logic signed [DATA_W-1:0]   mean_rate_x;
      logic signed [DATA_W-1:0]   mean_rate_y;
      logic signed [DATA_W-1:0]   mean_rate_z;
      logic signed [DATA_W-1:0]   mean_accel_x;
      logic signed [DATA_W-1:0]   mean_accel_y;
      logic signed [DATA_W-1:0]   mean_accel_z;
      logic signed [DATA_W-1:0]   mean_temperature;
      logic        [STATUS_W-1:0] status_union;
      logic signed [DATA_W-1:0]   out_quat_w;
      logic signed [DATA_W-1:0]   out_quat_x;
      logic signed [DATA_W-1:0]   out_quat_y;
      logic signed [DATA_W-1:0]   out_quat_z;
   } rsp_payload_type;

endpackage

// ===== rtl/core/iba_channels_if.sv =====
// Valid/ready stream interfaces for IMU sample requests and averaged results.
interface iba_req_if;
   logic                     valid;
   logic                     ready;
   iba_pkg::req_payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

interface iba_rsp_if;
   logic                     valid;
   logic                     ready;
   iba_pkg::rsp_payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

// ===== rtl/core/imu_block_average_decimator.sv =====
// Top level of the IMU block averaging decimator: registers, accumulator, queue, divider.
//
// Accepts one IMU sample per request and emits one averaged result every
// block_size samples (zero counts as one, values above MAX_BLOCK saturate).
// The accumulator takes a sample every cycle while the queue has room. Each
// closed block goes into a QUEUE_DEPTH entry queue; the result side divides
// the seven channel sums by the sample count with one shared restoring
// divider, one quotient bit per cycle, then registers the result. Means are
// truncated toward zero. Request ready drops only while the queue is full.
// orientation_enable is applied when a block closes; with it low the result
// carries the identity quaternion (w = 1.0 in Q1.30). Writes to register
// indexes beyond the two defined ones are dropped. Write configuration only
// while the block is idle.
module imu_block_average_decimator #(
   parameter int MAX_BLOCK   = iba_pkg::DEFAULT_MAX_BLOCK,
   parameter int QUEUE_DEPTH = iba_pkg::DEFAULT_QUEUE_DEPTH
) (
   input  logic                            clock,
   input  logic                            reset,
   iba_req_if.sink                         req_ch,
   iba_rsp_if.source                       rsp_ch,
   input  logic                            csr_we,
   input  logic [iba_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [iba_pkg::CSR_DATA_W-1:0]  csr_wdata
);

   // sum of MAX_BLOCK 32-bit signed values
   localparam int SUM_W = 32 + $clog2(MAX_BLOCK);
   localparam int CNT_W = $clog2(MAX_BLOCK + 1);
   localparam int JOB_W = iba_pkg::NUM_CH * SUM_W + CNT_W + iba_pkg::STATUS_W
                          + iba_pkg::QUAT_N * iba_pkg::DATA_W;

   iba_pkg::cfg_type cfg_ff, cfg_in;

   logic             push, queue_full;
   logic [JOB_W-1:0] push_data;
   logic             job_valid, job_pop;
   logic [JOB_W-1:0] job_data;

   // config register file
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_index)
            iba_pkg::CSR_BLOCK_SIZE: cfg_in.block_size = csr_wdata[iba_pkg::BLOCK_SIZE_W-1:0];
            iba_pkg::CSR_ORIENT_EN:  cfg_in.orientation_enable = csr_wdata[0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.block_size         <= iba_pkg::BLOCK_SIZE_RESET;
         cfg_ff.orientation_enable <= 1'b1;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // accumulates samples, closes blocks
   iba_front #(
      .MAX_BLOCK (MAX_BLOCK),
      .SUM_W     (SUM_W),
      .CNT_W     (CNT_W),
      .JOB_W     (JOB_W)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req        (req_ch),
      .cfg        (cfg_ff),
      .push       (push),
      .push_data  (push_data),
      .queue_full (queue_full)
   );

   // closed blocks waiting for the divider
   iba_fifo #(
      .WIDTH (JOB_W),
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .full      (queue_full),
      .pop       (job_pop),
      .not_empty (job_valid),
      .pop_data  (job_data)
   );

   // serial means and output register
   iba_back #(
      .MAX_BLOCK (MAX_BLOCK),
      .SUM_W     (SUM_W),
      .CNT_W     (CNT_W),
      .JOB_W     (JOB_W)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .job_valid (job_valid),
      .job_data  (job_data),
      .job_pop   (job_pop),
      .rsp       (rsp_ch)
   );

endmodule

// ===== rtl/core/iba_fifo.sv =====
// Small register queue carrying closed blocks from the accumulator to the divider.
module iba_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = iba_pkg::DEFAULT_QUEUE_DEPTH
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   output logic             full,
   input  logic             pop,
   output logic             not_empty,
   output logic [WIDTH-1:0] pop_data
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] slot_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] fill_ff, fill_in;
   logic             do_push, do_pop;

   assign full      = (fill_ff == CNT_W'(DEPTH));
   assign not_empty = (fill_ff != '0);
   assign pop_data  = slot_ff[rd_ptr_ff];
   assign do_push   = push && !full;
   assign do_pop    = pop && not_empty;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      fill_in   = fill_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         fill_in = fill_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         fill_in = fill_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// ===== rtl/core/iba_front.sv =====
// Sample accumulator: sums channels, ORs status and closes blocks into the queue.
module iba_front #(
   parameter int MAX_BLOCK = iba_pkg::DEFAULT_MAX_BLOCK,
   parameter int SUM_W     = 32 + $clog2(MAX_BLOCK),
   parameter int CNT_W     = $clog2(MAX_BLOCK + 1),
   parameter int JOB_W     = iba_pkg::NUM_CH * SUM_W + CNT_W + iba_pkg::STATUS_W
                             + iba_pkg::QUAT_N * iba_pkg::DATA_W
) (
   input  logic                 clock,
   input  logic                 reset,
   iba_req_if.sink              req,
   input  iba_pkg::cfg_type     cfg,
   output logic                 push,
   output logic [JOB_W-1:0]     push_data,
   input  logic                 queue_full
);

   localparam int CMP_W = (CNT_W > iba_pkg::BLOCK_SIZE_W) ? CNT_W : iba_pkg::BLOCK_SIZE_W;

   logic signed [SUM_W-1:0]                   sums_ff [iba_pkg::NUM_CH];
   logic signed [SUM_W-1:0]                   sums_in [iba_pkg::NUM_CH];
   logic        [CNT_W-1:0]                   count_ff, count_in;
   logic        [iba_pkg::STATUS_W-1:0]       status_ff, status_in;
   logic signed [iba_pkg::DATA_W-1:0]         ch_in [iba_pkg::NUM_CH];
   logic signed [SUM_W-1:0]                   sums_next [iba_pkg::NUM_CH];
   logic        [CNT_W-1:0]                   count_next;
   logic        [iba_pkg::STATUS_W-1:0]       status_next;
   logic        [CMP_W-1:0]                   bs_ext, limit;
   logic [iba_pkg::NUM_CH-1:0][SUM_W-1:0]     job_sums;
   logic [iba_pkg::QUAT_N-1:0][iba_pkg::DATA_W-1:0] job_quat;
   logic                                      accept, close;

   assign req.ready = !queue_full;
   assign accept    = req.valid && req.ready;

   assign ch_in[0] = req.payload.rate_x;
   assign ch_in[1] = req.payload.rate_y;
   assign ch_in[2] = req.payload.rate_z;
   assign ch_in[3] = req.payload.accel_x;
   assign ch_in[4] = req.payload.accel_y;
   assign ch_in[5] = req.payload.accel_z;
   assign ch_in[6] = req.payload.temperature;

   // zero means one, anything past the maximum saturates
   assign bs_ext = CMP_W'(cfg.block_size);
   assign limit  = (bs_ext == '0)              ? CMP_W'(1) :
                   (bs_ext > CMP_W'(MAX_BLOCK)) ? CMP_W'(MAX_BLOCK) : bs_ext;

   assign count_next  = count_ff + 1'b1;
   assign status_next = status_ff | req.payload.status_word;
   assign close       = CMP_W'(count_next) >= limit;

   always_comb begin
      for (int i = 0; i < iba_pkg::NUM_CH; i++) begin
         sums_next[i] = sums_ff[i] + SUM_W'(ch_in[i]);
         job_sums[i]  = sums_next[i];
      end
   end

   always_comb begin
      if (cfg.orientation_enable) begin
         job_quat[3] = req.payload.quat_w;
         job_quat[2] = req.payload.quat_x;
         job_quat[1] = req.payload.quat_y;
         job_quat[0] = req.payload.quat_z;
      end else begin
         job_quat[3] = iba_pkg::QUAT_ONE;
         job_quat[2] = '0;
         job_quat[1] = '0;
         job_quat[0] = '0;
      end
   end

   assign push      = accept && close;
   assign push_data = {job_sums, count_next, status_next, job_quat};

   always_comb begin
      for (int i = 0; i < iba_pkg::NUM_CH; i++) begin
         sums_in[i] = sums_ff[i];
      end
      count_in  = count_ff;
      status_in = status_ff;
      if (accept) begin
         for (int i = 0; i < iba_pkg::NUM_CH; i++) begin
            sums_in[i] = close ? '0 : sums_next[i];
         end
         count_in  = close ? '0 : count_next;
         status_in = close ? '0 : status_next;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < iba_pkg::NUM_CH; i++) begin
            sums_ff[i] <= '0;
         end
         count_ff  <= '0;
         status_ff <= '0;
      end else begin
         for (int i = 0; i < iba_pkg::NUM_CH; i++) begin
            sums_ff[i] <= sums_in[i];
         end
         count_ff  <= count_in;
         status_ff <= status_in;
      end
   end

endmodule

// ===== rtl/core/iba_back.sv =====
// Mean engine: shared bit-serial divider over seven channels plus result register.
module iba_back #(
   parameter int MAX_BLOCK = iba_pkg::DEFAULT_MAX_BLOCK,
   parameter int SUM_W     = 32 + $clog2(MAX_BLOCK),
   parameter int CNT_W     = $clog2(MAX_BLOCK + 1),
   parameter int JOB_W     = iba_pkg::NUM_CH * SUM_W + CNT_W + iba_pkg::STATUS_W
                             + iba_pkg::QUAT_N * iba_pkg::DATA_W
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             job_valid,
   input  logic [JOB_W-1:0] job_data,
   output logic             job_pop,
   iba_rsp_if.source        rsp
);

   localparam int STEP_W = $clog2(SUM_W);
   localparam int CH_W   = $clog2(iba_pkg::NUM_CH);
   localparam int DW     = iba_pkg::DATA_W;

   typedef enum logic [1:0] {S_IDLE, S_LOAD, S_DIV, S_OUT} state_type;

   logic [iba_pkg::NUM_CH-1:0][SUM_W-1:0] j_sums;
   logic [CNT_W-1:0]                      j_count;
   logic [iba_pkg::STATUS_W-1:0]          j_status;
   logic [iba_pkg::QUAT_N-1:0][DW-1:0]    j_quat;

   state_type                             state_ff, state_in;
   logic [iba_pkg::NUM_CH-1:0][SUM_W-1:0] sums_ff, sums_in;
   logic [CNT_W-1:0]                      count_ff, count_in;
   logic [iba_pkg::STATUS_W-1:0]          status_ff, status_in;
   logic [iba_pkg::QUAT_N-1:0][DW-1:0]    quat_ff, quat_in;
   logic [iba_pkg::NUM_CH-1:0][DW-1:0]    mean_ff, mean_in;
   logic [CH_W-1:0]                       ch_ff, ch_in;
   logic [STEP_W-1:0]                     step_ff, step_in;
   logic [SUM_W-1:0]                      dvd_ff, dvd_in;
   logic [CNT_W-1:0]                      rem_ff, rem_in;
   logic                                  neg_ff, neg_in;

   logic [SUM_W-1:0]                      sel_sum, sel_mag, dvd_step;
   logic [CNT_W:0]                        rem_sh, rem_sub;
   logic                                  ge;
   logic [DW-1:0]                         quo_lo;

   assign {j_sums, j_count, j_status, j_quat} = job_data;

   assign sel_sum = sums_ff[ch_ff];
   assign sel_mag = sel_sum[SUM_W-1] ? (SUM_W'(0) - sel_sum) : sel_sum;

   // restoring divide, one quotient bit per cycle
   assign rem_sh   = {rem_ff, dvd_ff[SUM_W-1]};
   assign ge       = rem_sh >= {1'b0, count_ff};
   assign rem_sub  = rem_sh - {1'b0, count_ff};
   assign dvd_step = {dvd_ff[SUM_W-2:0], ge};
   assign quo_lo   = dvd_step[DW-1:0];

   assign job_pop   = (state_ff == S_IDLE) && job_valid;
   assign rsp.valid = (state_ff == S_OUT);

   assign rsp.payload.mean_rate_x      = mean_ff[0];
   assign rsp.payload.mean_rate_y      = mean_ff[1];
   assign rsp.payload.mean_rate_z      = mean_ff[2];
   assign rsp.payload.mean_accel_x     = mean_ff[3];
   assign rsp.payload.mean_accel_y     = mean_ff[4];
   assign rsp.payload.mean_accel_z     = mean_ff[5];
   assign rsp.payload.mean_temperature = mean_ff[6];
   assign rsp.payload.status_union     = status_ff;
   assign rsp.payload.out_quat_w       = quat_ff[3];
   assign rsp.payload.out_quat_x       = quat_ff[2];
   assign rsp.payload.out_quat_y       = quat_ff[1];
   assign rsp.payload.out_quat_z       = quat_ff[0];

   always_comb begin
      state_in  = state_ff;
      sums_in   = sums_ff;
      count_in  = count_ff;
      status_in = status_ff;
      quat_in   = quat_ff;
      mean_in   = mean_ff;
      ch_in     = ch_ff;
      step_in   = step_ff;
      dvd_in    = dvd_ff;
      rem_in    = rem_ff;
      neg_in    = neg_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (job_valid) begin
               sums_in   = j_sums;
               count_in  = j_count;
               status_in = j_status;
               quat_in   = j_quat;
               ch_in     = '0;
               state_in  = S_LOAD;
            end
         end
         S_LOAD: begin
            dvd_in   = sel_mag;
            neg_in   = sel_sum[SUM_W-1];
            rem_in   = '0;
            step_in  = '0;
            state_in = S_DIV;
         end
         S_DIV: begin
            dvd_in  = dvd_step;
            rem_in  = ge ? rem_sub[CNT_W-1:0] : rem_sh[CNT_W-1:0];
            step_in = step_ff + 1'b1;
            if (step_ff == STEP_W'(SUM_W - 1)) begin
               mean_in[ch_ff] = neg_ff ? (DW'(0) - quo_lo) : quo_lo;
               if (ch_ff == CH_W'(iba_pkg::NUM_CH - 1)) begin
                  state_in = S_OUT;
               end else begin
                  ch_in    = ch_ff + 1'b1;
                  state_in = S_LOAD;
               end
            end
         end
         S_OUT: begin
            if (rsp.ready) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
      sums_ff   <= sums_in;
      count_ff  <= count_in;
      status_ff <= status_in;
      quat_ff   <= quat_in;
      mean_ff   <= mean_in;
      ch_ff     <= ch_in;
      step_ff   <= step_in;
      dvd_ff    <= dvd_in;
      rem_ff    <= rem_in;
      neg_ff    <= neg_in;
   end

endmodule

// ===== test/imu_block_average_decimator_checker.sv =====
`timescale 1ns / 1ps
// Result checker for the IMU block averager: mirrors the registers, predicts block means.
module imu_block_average_decimator_checker (
   input  logic                            clock,
   input  logic                            reset,
   iba_req_if                              req_ch,
   iba_rsp_if                              rsp_ch,
   input  logic                            csr_we,
   input  logic [iba_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [iba_pkg::CSR_DATA_W-1:0]  csr_wdata,
   output int                              error_count,
   output int                              pending_count
);

   localparam int SUM_W       = iba_pkg::DATA_W + $clog2(iba_pkg::DEFAULT_MAX_BLOCK);
   localparam int MAX_REPORTS = 10;

   // mirrored block state
   logic signed [SUM_W-1:0]             chan_sum [iba_pkg::NUM_CH];
   logic [iba_pkg::BLOCK_SIZE_W-1:0]    samples_in_block;
   logic [iba_pkg::STATUS_W-1:0]        status_or;
   logic [iba_pkg::DATA_W-1:0]          kept_quat [iba_pkg::QUAT_N];
   iba_pkg::cfg_type                    cfg_shadow;

   iba_pkg::rsp_payload_type            expected_means [$];
   iba_pkg::rsp_payload_type            want;
   int                                  mismatches;
   int                                  results_seen;

   function automatic logic [iba_pkg::DATA_W-1:0] mean_of(
         logic signed [SUM_W-1:0] sum, logic [iba_pkg::BLOCK_SIZE_W-1:0] n);
      longint q;
      q = longint'(sum) / longint'(n);   // SV division truncates toward zero
      return q[iba_pkg::DATA_W-1:0];
   endfunction

   task automatic clear_block();
      foreach (chan_sum[i]) chan_sum[i] = '0;
      foreach (kept_quat[i]) kept_quat[i] = '0;
      samples_in_block = '0;
      status_or = '0;
   endtask

   // one accepted sample; queues a mean when the block closes
   task automatic take_sample(input iba_pkg::req_payload_type s);
      logic signed [iba_pkg::DATA_W-1:0] lin [iba_pkg::NUM_CH];
      logic [iba_pkg::BLOCK_SIZE_W-1:0]  limit;
      iba_pkg::rsp_payload_type          r;
      lin = '{s.rate_x, s.rate_y, s.rate_z, s.accel_x, s.accel_y, s.accel_z,
              s.temperature};
      limit = cfg_shadow.block_size;
      if (limit == '0) limit = iba_pkg::BLOCK_SIZE_W'(1);
      if (limit > iba_pkg::DEFAULT_MAX_BLOCK)
         limit = iba_pkg::BLOCK_SIZE_W'(iba_pkg::DEFAULT_MAX_BLOCK);
      foreach (lin[i]) chan_sum[i] = chan_sum[i] + lin[i];
      status_or = status_or | s.status_word;
      kept_quat = '{s.quat_w, s.quat_x, s.quat_y, s.quat_z};
      samples_in_block = samples_in_block + 1'b1;
      if (samples_in_block >= limit) begin
         r.mean_rate_x      = mean_of(chan_sum[0], samples_in_block);
         r.mean_rate_y      = mean_of(chan_sum[1], samples_in_block);
         r.mean_rate_z      = mean_of(chan_sum[2], samples_in_block);
         r.mean_accel_x     = mean_of(chan_sum[3], samples_in_block);
         r.mean_accel_y     = mean_of(chan_sum[4], samples_in_block);
         r.mean_accel_z     = mean_of(chan_sum[5], samples_in_block);
         r.mean_temperature = mean_of(chan_sum[6], samples_in_block);
         r.status_union     = status_or;
         if (cfg_shadow.orientation_enable) begin
            r.out_quat_w = kept_quat[0];
            r.out_quat_x = kept_quat[1];
            r.out_quat_y = kept_quat[2];
            r.out_quat_z = kept_quat[3];
         end else begin
            r.out_quat_w = iba_pkg::QUAT_ONE;
            r.out_quat_x = '0;
            r.out_quat_y = '0;
            r.out_quat_z = '0;
         end
         expected_means.push_back(r);
         clear_block();
      end
   endtask

   task automatic check_field(input string name, input logic [iba_pkg::DATA_W-1:0] exp_val,
                              input logic [iba_pkg::DATA_W-1:0] act_val);
      if (act_val !== exp_val) begin
         mismatches++;
         if (mismatches <= MAX_REPORTS)
            $display("mismatch in result %0d: %s expected %h got %h",
                     results_seen, name, exp_val, act_val);
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         clear_block();
         cfg_shadow.block_size = iba_pkg::BLOCK_SIZE_RESET;
         cfg_shadow.orientation_enable = 1'b1;
         expected_means.delete();
         mismatches = 0;
         results_seen = 0;
      end else begin
         if (csr_we) begin
            case (csr_index)
               iba_pkg::CSR_BLOCK_SIZE:
                  cfg_shadow.block_size = csr_wdata[iba_pkg::BLOCK_SIZE_W-1:0];
               iba_pkg::CSR_ORIENT_EN:
                  cfg_shadow.orientation_enable = csr_wdata[0];
               default: ;
            endcase
         end
         if (rsp_ch.valid && rsp_ch.ready) begin
            results_seen++;
            if (expected_means.size() == 0) begin
               mismatches++;
               if (mismatches <= MAX_REPORTS)
                  $display("mismatch: result %0d arrived with none pending, mean_rate_x %h",
                           results_seen, rsp_ch.payload.mean_rate_x);
            end else begin
               want = expected_means.pop_front();
               check_field("mean_rate_x", want.mean_rate_x, rsp_ch.payload.mean_rate_x);
               check_field("mean_rate_y", want.mean_rate_y, rsp_ch.payload.mean_rate_y);
               check_field("mean_rate_z", want.mean_rate_z, rsp_ch.payload.mean_rate_z);
               check_field("mean_accel_x", want.mean_accel_x, rsp_ch.payload.mean_accel_x);
               check_field("mean_accel_y", want.mean_accel_y, rsp_ch.payload.mean_accel_y);
               check_field("mean_accel_z", want.mean_accel_z, rsp_ch.payload.mean_accel_z);
               check_field("mean_temperature", want.mean_temperature,
                           rsp_ch.payload.mean_temperature);
               check_field("status_union", iba_pkg::DATA_W'(want.status_union),
                           iba_pkg::DATA_W'(rsp_ch.payload.status_union));
               check_field("out_quat_w", want.out_quat_w, rsp_ch.payload.out_quat_w);
               check_field("out_quat_x", want.out_quat_x, rsp_ch.payload.out_quat_x);
               check_field("out_quat_y", want.out_quat_y, rsp_ch.payload.out_quat_y);
               check_field("out_quat_z", want.out_quat_z, rsp_ch.payload.out_quat_z);
            end
         end
         if (req_ch.valid && req_ch.ready)
            take_sample(req_ch.payload);
      end
      error_count = mismatches;
      pending_count = expected_means.size();
   end

endmodule

// ===== test/imu_block_average_decimator_tb.sv =====
`timescale 1ns / 1ps
// Testbench top for the IMU block averager: clock, reset, request stimulus and verdict.
module imu_block_average_decimator_tb;

   localparam int HIGH_NS        = 4;
   localparam int LOW_NS         = 4;
   localparam int RESET_CYCLES   = 6;
   localparam int MAX_IDLE       = 17;
   // allowance for one result to pass through the divider over all seven channels
   localparam int RESULT_LATENCY = 320;
   localparam int RANDOM_ITEMS   = 1800;
   localparam int TAIL_LIMIT     = 20000;
   localparam int LONG_HOLD      = 1500;
   localparam int DW             = iba_pkg::DATA_W;
   localparam int SW             = iba_pkg::STATUS_W;
   localparam int IW             = iba_pkg::CSR_INDEX_W;
   localparam int CW             = iba_pkg::CSR_DATA_W;

   // register indexes with no register behind them; writes must be dropped
   localparam logic [IW-1:0] CSR_SPARE_LO = 2'd2;
   localparam logic [IW-1:0] CSR_SPARE_HI = 2'd3;

   localparam logic [DW-1:0] WORD_MAX = 32'h7FFF_FFFF;
   localparam logic [DW-1:0] WORD_MIN = 32'h8000_0000;

   logic          clock     = 1'b0;
   logic          reset     = 1'b1;
   logic          csr_we    = 1'b0;
   logic [IW-1:0] csr_index = '0;
   logic [CW-1:0] csr_wdata = '0;

   iba_req_if req_ch ();
   iba_rsp_if rsp_ch ();

   int error_count;
   int pending_count;

   // knobs for the request driver and the result taker
   bit req_no_gap   = 1'b0;
   bit rsp_no_stall = 1'b0;
   int rsp_hold_req = 0;

   imu_block_average_decimator dut (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_ch),
      .rsp_ch    (rsp_ch),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   imu_block_average_decimator_checker mean_check (
      .clock         (clock),
      .reset         (reset),
      .req_ch        (req_ch),
      .rsp_ch        (rsp_ch),
      .csr_we        (csr_we),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata),
      .error_count   (error_count),
      .pending_count (pending_count)
   );

   always begin
      #HIGH_NS clock = 1'b1;
      #LOW_NS clock = 1'b0;
   end

   // hard stop in case the block hangs
   initial begin
      #40_000_000;
      $display("FAILED: results differ");
      $finish;
   end

   // word biased toward the corners: full scale, zero, -1, small values around zero
   function automatic logic [DW-1:0] pick_word();
      case ($urandom_range(0, 9))
         0: return WORD_MAX;
         1: return WORD_MIN;
         2: return '0;
         3: return '1;
         4: return DW'($urandom_range(0, 511)) - DW'(256);
         default: return $urandom();
      endcase
   endfunction

   function automatic iba_pkg::req_payload_type random_sample();
      iba_pkg::req_payload_type s;
      s.rate_x      = pick_word();
      s.rate_y      = pick_word();
      s.rate_z      = pick_word();
      s.accel_x     = pick_word();
      s.accel_y     = pick_word();
      s.accel_z     = pick_word();
      s.temperature = pick_word();
      case ($urandom_range(0, 5))
         0: s.status_word = '0;
         1: s.status_word = '1;
         2: s.status_word = SW'(1) << $urandom_range(0, SW - 1);
         default: s.status_word = SW'($urandom());
      endcase
      s.quat_w = pick_word();
      s.quat_x = pick_word();
      s.quat_y = pick_word();
      s.quat_z = pick_word();
      return s;
   endfunction

   // every word field carries the same value
   function automatic iba_pkg::req_payload_type uniform_sample(logic [DW-1:0] v,
                                                               logic [SW-1:0] st);
      iba_pkg::req_payload_type s;
      s.rate_x      = v;
      s.rate_y      = v;
      s.rate_z      = v;
      s.accel_x     = v;
      s.accel_y     = v;
      s.accel_z     = v;
      s.temperature = v;
      s.status_word = st;
      s.quat_w      = v;
      s.quat_x      = v;
      s.quat_y      = v;
      s.quat_z      = v;
      return s;
   endfunction

   // Offer one request after a random gap; returns just after the edge that took it.
   // valid stays high when the next request follows with no gap.
   task automatic send_sample(input iba_pkg::req_payload_type s);
      int gap;
      gap = req_no_gap ? 0 : $urandom_range(0, MAX_IDLE);
      @(negedge clock);
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.payload <= s;
      do @(posedge clock); while (!req_ch.ready);
   endtask

   task automatic stop_requests();
      @(negedge clock);
      req_ch.valid <= 1'b0;
   endtask

   // Sender pause: all results back, then room for a block that closed with no
   // result still in flight inside the divider.
   task automatic wait_idle();
      stop_requests();
      while (pending_count != 0) @(negedge clock);
      repeat (RESULT_LATENCY) @(negedge clock);
   endtask

   task automatic write_csr(input logic [IW-1:0] idx,
                            input logic [CW-1:0] data);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(negedge clock);
      csr_we    <= 1'b0;
   endtask

   // Result side: random stall before each result, counted only while a result
   // is offered, plus long hold-offs asked for by the stimulus.
   initial begin
      int stall_left;
      int hold_left;
      int served;
      stall_left = 0;
      hold_left = 0;
      served = 0;
      rsp_ch.ready = 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_ch.valid && rsp_ch.ready) begin
            served++;
            // now and then switch to a stretch with no stalls
            if (served % 40 == 0) rsp_no_stall = ($urandom_range(0, 3) == 0);
            stall_left = rsp_no_stall ? 0 : $urandom_range(0, MAX_IDLE);
         end
         @(negedge clock);
         if (rsp_hold_req > 0) begin
            hold_left = rsp_hold_req;
            rsp_hold_req = 0;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ch.ready <= 1'b0;
         end else if (stall_left > 0) begin
            if (rsp_ch.valid) stall_left--;
            rsp_ch.ready <= 1'b0;
         end else begin
            rsp_ch.ready <= 1'b1;
         end
      end
   end

   initial begin
      iba_pkg::req_payload_type s;
      int size;
      int eff;
      int n;
      int i;
      int random_items;
      bit orient;
      req_ch.valid = 1'b0;
      req_ch.payload = '0;
      random_items = 0;
      repeat (RESET_CYCLES) @(negedge clock);
      reset <= 1'b0;

      // ---- directed ----
      // reset config: block of one, orientation passed through
      send_sample(uniform_sample(WORD_MAX, 16'hFFFF));
      send_sample(uniform_sample(WORD_MIN, 16'h0000));
      send_sample(uniform_sample('0, 16'h8001));
      send_sample(uniform_sample('1, 16'h5555));

      // orientation off: identity quaternion in the result
      wait_idle();
      write_csr(iba_pkg::CSR_ORIENT_EN, CW'(0));
      send_sample(random_sample());

      // block size zero acts as one
      wait_idle();
      write_csr(iba_pkg::CSR_BLOCK_SIZE, CW'(0));
      write_csr(iba_pkg::CSR_ORIENT_EN, CW'(1));
      send_sample(random_sample());
      send_sample(random_sample());

      // pairs: full-scale negative sum, -1/2 -> 0, -3/2 -> -1 (toward zero)
      wait_idle();
      write_csr(iba_pkg::CSR_BLOCK_SIZE, CW'(2));
      send_sample(uniform_sample(WORD_MIN, 16'h0000));
      send_sample(uniform_sample(WORD_MIN, 16'h0000));
      send_sample(uniform_sample(WORD_MAX, 16'h0001));
      send_sample(uniform_sample(WORD_MIN, 16'h0100));
      send_sample(uniform_sample(32'hFFFF_FFFF, 16'h0002));
      send_sample(uniform_sample(32'hFFFF_FFFE, 16'h0040));

      // spare register indexes must not disturb the block size of three
      wait_idle();
      write_csr(iba_pkg::CSR_BLOCK_SIZE, CW'(3));
      write_csr(CSR_SPARE_LO, CW'(1));
      write_csr(CSR_SPARE_HI, CW'(0));
      send_sample(uniform_sample(DW'(1), 16'h0001));
      send_sample(uniform_sample(DW'(1), 16'h0002));
      send_sample(uniform_sample('0, 16'h0004));

      // largest block, then lowered mid-block: next request closes all four;
      // orientation read at close time
      wait_idle();
      write_csr(iba_pkg::CSR_BLOCK_SIZE, CW'(iba_pkg::DEFAULT_MAX_BLOCK));
      send_sample(random_sample());
      send_sample(random_sample());
      send_sample(random_sample());
      wait_idle();
      write_csr(iba_pkg::CSR_BLOCK_SIZE, CW'(2));
      write_csr(iba_pkg::CSR_ORIENT_EN, CW'(0));
      send_sample(random_sample());

      // ---- random ----
      // One saturated block: 2047 clamps to the max, one channel pinned at each
      // full-scale end so the sums reach the accumulator limits.
      wait_idle();
      write_csr(iba_pkg::CSR_BLOCK_SIZE, '1);
      write_csr(iba_pkg::CSR_ORIENT_EN, CW'($urandom_range(0, 1)));
      req_no_gap = 1'b0;
      for (i = 0; i < iba_pkg::DEFAULT_MAX_BLOCK; i++) begin
         s = random_sample();
         s.rate_x = WORD_MIN;
         s.accel_x = WORD_MAX;
         send_sample(s);
      end
      random_items += iba_pkg::DEFAULT_MAX_BLOCK;

      // Backpressure: result side held off while requests keep coming, so the
      // result queue fills and request ready drops.
      wait_idle();
      write_csr(iba_pkg::CSR_BLOCK_SIZE, CW'(1));
      write_csr(iba_pkg::CSR_ORIENT_EN, CW'(1));
      rsp_hold_req = LONG_HOLD;
      req_no_gap = 1'b1;
      for (i = 0; i < 10; i++) send_sample(random_sample());
      random_items += 10;

      // Phases of mostly small blocks; some leave a partial block behind that
      // the next phase's size then closes.
      while (random_items < RANDOM_ITEMS) begin
         wait_idle();
         case ($urandom_range(0, 19))
            0:                  size = 0;
            14, 15, 16, 17, 18: size = $urandom_range(7, 40);
            19:                 size = $urandom_range(41, 160);
            default:            size = $urandom_range(1, 6);
         endcase
         orient = 1'($urandom_range(0, 1));
         if ($urandom_range(0, 7) == 0)
            write_csr($urandom_range(0, 1) ? CSR_SPARE_LO : CSR_SPARE_HI,
                      CW'($urandom()));
         write_csr(iba_pkg::CSR_BLOCK_SIZE, CW'(size));
         write_csr(iba_pkg::CSR_ORIENT_EN, CW'(orient));
         req_no_gap = ($urandom_range(0, 3) == 0);
         if ($urandom_range(0, 9) == 0) rsp_hold_req = $urandom_range(100, 600);
         eff = (size == 0) ? 1 : size;
         n = eff * $urandom_range(1, 5);
         if ($urandom_range(0, 2) == 0) n += $urandom_range(0, eff - 1);
         for (i = 0; i < n; i++) send_sample(random_sample());
         random_items += n;
      end

      // ---- wind down ----
      stop_requests();
      for (i = 0; i < TAIL_LIMIT && pending_count != 0; i++) @(negedge clock);
      repeat (RESULT_LATENCY) @(negedge clock);
      if (pending_count != 0)
         $display("%0d expected results never arrived", pending_count);
      if (error_count == 0 && pending_count == 0)
         $display("PASSED: all results match");
      else
         $display("FAILED: results differ");
      $finish;
   end

endmodule

// ===== files.f =====
rtl/core/iba_pkg.sv
rtl/core/iba_channels_if.sv
rtl/core/iba_fifo.sv
rtl/core/iba_front.sv
rtl/core/iba_back.sv
rtl/core/imu_block_average_decimator.sv
test/imu_block_average_decimator_checker.sv
test/imu_block_average_decimator_tb.sv
